>>> rtl/crsa_pkg.sv
// Package for the complex RPN stack ALU: sizes, action and status codes.
package crsa_pkg;
  localparam int StackDepth = 16;
  localparam int FracBits = 16;
  localparam int PtrW = $clog2(StackDepth);
  localparam int CntW = $clog2(StackDepth + 1);
  localparam int DepthW = 5;
  localparam int DataW = 32;
  localparam int ProdW = 2 * DataW;
  localparam int DivSteps = ProdW + FracBits;
  localparam int StepW = $clog2(DivSteps + 1);

  localparam logic [2:0] ActPush = 3'd0;
  localparam logic [2:0] ActAdd = 3'd1;
  localparam logic [2:0] ActSub = 3'd2;
  localparam logic [2:0] ActMul = 3'd3;
  localparam logic [2:0] ActDiv = 3'd4;
  localparam logic [2:0] ActClear = 3'd5;

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StFew = 3'd1;
  localparam logic [2:0] StFull = 3'd2;
  localparam logic [2:0] StDivZero = 3'd3;
  localparam logic [2:0] StBadAct = 3'd4;

  typedef logic signed [DataW-1:0] word_t;
endpackage

>>> rtl/complex_rpn_stack_alu.sv
// Complex RPN stack ALU top level: sequencer, shared multiplier and serial divider.
//
//  channel | dir | tdata (low bit up)                          | tuser
//  s_axis  | in  | push_re[31:0], push_im[63:32]               | action[2:0]
//  m_axis  | out | top_re[31:0], top_im[63:32], depth[68:64], status[71:69] | -
//
// Push, clear, too few operands, stack full and bad action skip the arithmetic.
// Add/sub read both operands and write back. Multiply: five passes through one
// shared 32x32 multiplier. Divide: two restoring divisions (one per quotient part)
// after seven multiplier passes; divide by zero stops after those passes.
// Reset clears the count and the sequencer only; stack RAM is not cleared.
// s_axis_tready is low from acceptance until the result word is taken.
module complex_rpn_stack_alu (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // push_re, push_im
  input  logic [2:0]  s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata   // top_re, top_im, depth, status
);
  localparam int DW = crsa_pkg::DataW;
  localparam int PW = crsa_pkg::ProdW;
  localparam int PtrW = crsa_pkg::PtrW;
  localparam int CntW = crsa_pkg::CntW;
  // quotient clamp, above the point where the result saturates
  localparam logic [PW-1:0] QuoCap = PW'(64'h2_0000_0000);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_RD_T = 5'd1;
  localparam logic [4:0] S_RD_S = 5'd2;
  localparam logic [4:0] S_LAT = 5'd3;
  localparam logic [4:0] S_MUL = 5'd4;
  localparam logic [4:0] S_SUM = 5'd5;
  localparam logic [4:0] S_DIV = 5'd6;
  localparam logic [4:0] S_WR = 5'd7;
  localparam logic [4:0] S_TOP = 5'd8;
  localparam logic [4:0] S_TOPW = 5'd9;
  localparam logic [4:0] S_OUT = 5'd10;
  localparam logic [4:0] S_DEN = 5'd11;

  logic [4:0] state;
  logic [2:0] action;
  logic [2:0] status;
  logic [CntW-1:0] count;
  logic [2:0] mstep;
  logic [crsa_pkg::StepW-1:0] dstep;
  logic dpart;
  crsa_pkg::word_t tr, ti, sr, si, rr, ri;
  logic signed [PW-1:0] prod, p0, p1, p2, p3;
  logic [PW:0] den;
  logic [PW-1:0] dmag;
  logic dneg;
  logic [PW+1:0] rem;
  logic [PW-1:0] quo;
  logic [crsa_pkg::DepthW-1:0] o_depth;
  crsa_pkg::word_t o_re, o_im;

  logic we;
  logic [PtrW-1:0] waddr, raddr;
  logic [DW-1:0] rd_re, rd_im, wd_re, wd_im;

  crsa_ram #(.Width(DW), .Depth(crsa_pkg::StackDepth)) u_re (
    .clk, .we, .waddr, .wdata(wd_re), .raddr, .rdata(rd_re));
  crsa_ram #(.Width(DW), .Depth(crsa_pkg::StackDepth)) u_im (
    .clk, .we, .waddr, .wdata(wd_im), .raddr, .rdata(rd_im));

  // shared multiplier operands
  crsa_pkg::word_t ma, mb;
  always_comb begin
    case (mstep)
      3'd0: begin ma = tr; mb = sr; end
      3'd1: begin ma = ti; mb = si; end
      3'd2: begin ma = tr; mb = si; end
      3'd3: begin ma = ti; mb = sr; end
      3'd4: begin ma = sr; mb = sr; end
      default: begin ma = si; mb = si; end
    endcase
  end

  function automatic crsa_pkg::word_t sat_mag(input logic neg, input logic [PW:0] q);
    crsa_pkg::word_t r;
    if (!neg) r = (q > (PW+1)'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[DW-1:0];
    else if (q > (PW+1)'(33'h0_8000_0000)) r = 32'h8000_0000;
    else r = DW'(-$signed({1'b0, q[DW-1:0]}));
    return r;
  endfunction

  function automatic crsa_pkg::word_t sat_add(input crsa_pkg::word_t a,
                                              input crsa_pkg::word_t b);
    logic signed [DW:0] s;
    s = {a[DW-1], a} + {b[DW-1], b};
    if (s[DW] != s[DW-1]) return s[DW] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return s[DW-1:0];
  endfunction

  // sum of two products as sign and magnitude (65-bit exact)
  logic signed [PW:0] sum_a, sum_b, sum_s;
  logic [PW:0] sum_mag;
  always_comb begin
    if (action == crsa_pkg::ActMul) begin
      sum_a = dpart ? {p2[PW-1], p2} : {p0[PW-1], p0};
      sum_b = dpart ? {p3[PW-1], p3} : -{p1[PW-1], p1};
    end else begin
      sum_a = dpart ? {p3[PW-1], p3} : {p0[PW-1], p0};
      sum_b = dpart ? -{p2[PW-1], p2} : {p1[PW-1], p1};
    end
    sum_s = sum_a + sum_b;
    sum_mag = sum_s[PW] ? (PW+1)'(-sum_s) : (PW+1)'(sum_s);
  end

  logic [PW+1:0] rem_sh;
  logic bit_in;
  logic qbit;
  logic [PW-1:0] quo_sh;
  always_comb begin
    bit_in = (dstep < crsa_pkg::StepW'(PW)) ? dmag[PW-1] : 1'b0;
    rem_sh = {rem[PW:0], bit_in};
    qbit = (rem_sh >= {1'b0, den});
    quo_sh = {quo[PW-2:0], qbit};
  end

  always_comb begin
    we = 1'b0;
    waddr = PtrW'(count - CntW'(2));
    wd_re = rr;
    wd_im = ri;
    raddr = PtrW'(count - CntW'(1));
    if (state == S_IDLE && action == crsa_pkg::ActPush) begin
      waddr = PtrW'(count);
      wd_re = s_axis_tdata[DW-1:0];
      wd_im = s_axis_tdata[2*DW-1:DW];
    end
    unique case (state)
      S_RD_S: raddr = PtrW'(count - CntW'(2));
      S_WR: we = 1'b1;
      default: ;
    endcase
    if (state == S_IDLE && s_axis_tvalid && s_axis_tuser == crsa_pkg::ActPush
        && count < CntW'(crsa_pkg::StackDepth)) begin
      we = 1'b1;
      waddr = PtrW'(count);
      wd_re = s_axis_tdata[DW-1:0];
      wd_im = s_axis_tdata[2*DW-1:DW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      action <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (s_axis_tvalid) begin
          action <= s_axis_tuser;
          status <= crsa_pkg::StOk;
          unique case (s_axis_tuser) inside
            crsa_pkg::ActPush: begin
              if (count < CntW'(crsa_pkg::StackDepth)) count <= count + CntW'(1);
              else status <= crsa_pkg::StFull;
              state <= S_TOP;
            end
            crsa_pkg::ActClear: begin
              count <= '0;
              state <= S_TOP;
            end
            [crsa_pkg::ActAdd:crsa_pkg::ActDiv]: begin
              if (count < CntW'(2)) begin
                status <= crsa_pkg::StFew;
                state <= S_TOP;
              end else state <= S_RD_T;
            end
            default: begin
              status <= crsa_pkg::StBadAct;
              state <= S_TOP;
            end
          endcase
        end
        S_RD_T: state <= S_RD_S;
        S_RD_S: begin
          tr <= rd_re;
          ti <= rd_im;
          state <= S_LAT;
        end
        S_LAT: begin
          sr <= rd_re;
          si <= rd_im;
          mstep <= '0;
          dpart <= 1'b0;
          if (action == crsa_pkg::ActAdd) begin
            state <= S_WR;
          end else if (action == crsa_pkg::ActSub) begin
            state <= S_WR;
          end else state <= S_MUL;
        end
        S_MUL: begin
          prod <= ma * mb;
          mstep <= mstep + 3'd1;
          unique case (mstep)
            3'd0: ;
            3'd1: p0 <= prod;
            3'd2: p1 <= prod;
            3'd3: p2 <= prod;
            3'd4: p3 <= prod;
            3'd5: den <= {1'b0, prod};
            default: den <= den + {1'b0, prod};
          endcase
          if (action == crsa_pkg::ActMul && mstep == 3'd4) state <= S_SUM;
          if (mstep == 3'd6) state <= S_DEN;
        end
        S_DEN: begin
          if (den == '0) begin
            status <= crsa_pkg::StDivZero;
            state <= S_TOP;
          end else state <= S_SUM;
        end
        S_SUM: begin
          if (action == crsa_pkg::ActMul) begin
            if (!dpart) rr <= sat_mag(sum_s[PW], sum_mag >> crsa_pkg::FracBits);
            else ri <= sat_mag(sum_s[PW], sum_mag >> crsa_pkg::FracBits);
            dpart <= ~dpart;
            if (dpart) state <= S_WR;
          end else begin
            dmag <= sum_mag[PW-1:0];
            dneg <= sum_s[PW];
            rem <= '0;
            quo <= '0;
            dstep <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // one restoring step: remainder stays below den, so PW+2 bits suffice
          rem <= qbit ? rem_sh - {1'b0, den} : rem_sh;
          quo <= (quo_sh > QuoCap) ? QuoCap : quo_sh;
          if (dstep < crsa_pkg::StepW'(PW)) dmag <= {dmag[PW-2:0], 1'b0};
          dstep <= dstep + crsa_pkg::StepW'(1);
          if (dstep == crsa_pkg::StepW'(crsa_pkg::DivSteps)) begin
            if (!dpart) rr <= sat_mag(dneg, {1'b0, quo});
            else ri <= sat_mag(dneg, {1'b0, quo});
            dpart <= ~dpart;
            state <= dpart ? S_WR : S_SUM;
          end
        end
        S_WR: begin
          count <= count - CntW'(1);
          state <= S_TOP;
        end
        S_TOP: state <= S_TOPW;
        S_TOPW: begin
          o_depth <= crsa_pkg::DepthW'(count);
          o_re <= (count == '0) ? '0 : rd_re;
          o_im <= (count == '0) ? '0 : rd_im;
          state <= S_OUT;
        end
        S_OUT: if (m_axis_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      if (state == S_LAT) begin
        if (action == crsa_pkg::ActAdd) begin
          rr <= sat_add(tr, rd_re);
          ri <= sat_add(ti, rd_im);
        end else if (action == crsa_pkg::ActSub) begin
          if (rd_re == 32'h8000_0000) rr <= tr[DW-1] ? sat_add(tr + 32'sd1, 32'h7FFF_FFFF)
                                                    : 32'h7FFF_FFFF;
          else rr <= sat_add(tr, -rd_re);
          if (rd_im == 32'h8000_0000) ri <= ti[DW-1] ? sat_add(ti + 32'sd1, 32'h7FFF_FFFF)
                                                    : 32'h7FFF_FFFF;
          else ri <= sat_add(ti, -rd_im);
        end
      end
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata = {status, o_depth, o_im, o_re};

`ifndef NO_ASSERTIONS
  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(crsa_pkg::StackDepth)) else $error("count over depth");
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
  a_wr_pop: assert property (@(posedge clk) disable iff (rst)
    state == S_WR |=> count == $past(count) - CntW'(1)) else $error("pop count");
  a_err_keep: assert property (@(posedge clk) disable iff (rst)
    (state == S_TOP && status != crsa_pkg::StOk) |-> $stable(count))
    else $error("error changed stack");
`endif
endmodule

>>> rtl/crsa_ram.sv
// Generic single write, single registered read RAM.
module crsa_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> tb/tb_complex_rpn_stack_alu.sv
// Testbench for the complex RPN stack ALU: directed table, random words, scoreboard.
module tb_complex_rpn_stack_alu;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 3000000;
  localparam int NumRandom = 700;
  localparam logic [2:0] ActBad6 = 3'd6;
  localparam logic [2:0] ActBad7 = 3'd7;

  typedef struct packed {
    logic [2:0]      status;
    logic [4:0]      depth;
    crsa_pkg::word_t top_im;
    crsa_pkg::word_t top_re;
  } alu_result_t;

  typedef struct {
    logic [2:0]      act;
    crsa_pkg::word_t re;
    crsa_pkg::word_t im;
    bit              typed;
    alu_result_t     res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;  // push_re, push_im
  logic [2:0]  s_axis_tuser = '0;  // action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;       // top_re, top_im, depth, status

  complex_rpn_stack_alu dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  crsa_pkg::word_t stk_re [crsa_pkg::StackDepth];
  crsa_pkg::word_t stk_im [crsa_pkg::StackDepth];
  int              stk_cnt = 0;
  alu_result_t     pending_results[$];
  int              mismatches = 0;
  int              cycles = 0;
  bit              quiet = 1'b0;
  bit              hold_req = 1'b0;

  function automatic crsa_pkg::word_t sat_signmag(bit neg, logic [127:0] q);
    if (!neg) return (q > 128'h7FFF_FFFF) ? 32'sh7FFF_FFFF : crsa_pkg::word_t'(q[31:0]);
    if (q > 128'h8000_0000) q = 128'h8000_0000;
    return crsa_pkg::word_t'(-q[31:0]);
  endfunction

  // exact a + b as sign and magnitude
  function automatic void signmag(longint a, longint b, output bit neg,
                                  output logic [127:0] mag);
    logic signed [65:0] sa, sb, sum;
    sa = a;
    sb = b;
    sum = sa + sb;
    neg = sum < 0;
    mag = neg ? 128'(-sum) : 128'(sum);
  endfunction

  function automatic crsa_pkg::word_t mul_part(longint a, longint b);
    bit neg;
    logic [127:0] mag;
    signmag(a, b, neg, mag);
    return sat_signmag(neg, mag >> crsa_pkg::FracBits);
  endfunction

  function automatic crsa_pkg::word_t div_part(longint a, longint b, logic [127:0] den);
    bit neg;
    logic [127:0] mag, q;
    signmag(a, b, neg, mag);
    q = (mag << crsa_pkg::FracBits) / den;
    if (q > (128'd1 << 33)) q = 128'd1 << 33;
    return sat_signmag(neg, q);
  endfunction

  function automatic crsa_pkg::word_t sat_add(longint a, longint b);
    longint s;
    s = a + b;
    if (s > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (s < -64'sd2147483648) return 32'sh8000_0000;
    return crsa_pkg::word_t'(s);
  endfunction

  function automatic alu_result_t calc_step(logic [2:0] act, crsa_pkg::word_t re,
                                            crsa_pkg::word_t im);
    alu_result_t r;
    longint tr, ti, sr, si;
    logic [127:0] den;
    crsa_pkg::word_t rr, ri;
    r = '0;
    r.status = crsa_pkg::StOk;
    if (act == crsa_pkg::ActPush) begin
      if (stk_cnt >= crsa_pkg::StackDepth) r.status = crsa_pkg::StFull;
      else begin
        stk_re[stk_cnt] = re;
        stk_im[stk_cnt] = im;
        stk_cnt++;
      end
    end else if (act >= crsa_pkg::ActAdd && act <= crsa_pkg::ActDiv) begin
      if (stk_cnt < 2) r.status = crsa_pkg::StFew;
      else begin
        tr = stk_re[stk_cnt-1];
        ti = stk_im[stk_cnt-1];
        sr = stk_re[stk_cnt-2];
        si = stk_im[stk_cnt-2];
        rr = '0;
        ri = '0;
        case (act)
          crsa_pkg::ActAdd: begin
            rr = sat_add(tr, sr);
            ri = sat_add(ti, si);
          end
          crsa_pkg::ActSub: begin
            rr = sat_add(tr, -sr);
            ri = sat_add(ti, -si);
          end
          crsa_pkg::ActMul: begin
            rr = mul_part(tr * sr, -(si * ti));
            ri = mul_part(tr * si, ti * sr);
          end
          default: begin
            den = 128'(64'(sr * sr)) + 128'(64'(si * si));
            if (den == 0) r.status = crsa_pkg::StDivZero;
            else begin
              rr = div_part(tr * sr, ti * si, den);
              ri = div_part(ti * sr, -(tr * si), den);
            end
          end
        endcase
        if (r.status == crsa_pkg::StOk) begin
          stk_re[stk_cnt-2] = rr;
          stk_im[stk_cnt-2] = ri;
          stk_cnt--;
        end
      end
    end else if (act == crsa_pkg::ActClear) stk_cnt = 0;
    else r.status = crsa_pkg::StBadAct;
    if (stk_cnt > 0) begin
      r.top_re = stk_re[stk_cnt-1];
      r.top_im = stk_im[stk_cnt-1];
    end
    r.depth = 5'(stk_cnt);
    return r;
  endfunction

  // drive one word, then record the expectation when it is taken
  task automatic send_word(logic [2:0] act, crsa_pkg::word_t re, crsa_pkg::word_t im,
                           bit typed, alu_result_t res);
    alu_result_t pred;
    if (!quiet && $urandom_range(99) < 19) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {im, re};
    do @(posedge clk); while (!s_axis_tready);
    pred = calc_step(act, re, im);
    pending_results.push_back(typed ? res : pred);
  endtask

  function automatic crsa_pkg::word_t rand_part();
    case ($urandom_range(5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return crsa_pkg::word_t'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      3: return '0;
      default: return crsa_pkg::word_t'($urandom);
    endcase
  endfunction

  // receiver
  always @(posedge clk) begin
    if (hold_req) m_axis_tready <= 1'b0;
    else m_axis_tready <= quiet || ($urandom_range(99) >= 19);
  end

  // scoreboard
  always @(posedge clk) begin
    alu_result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp re=%h im=%h depth=%0d st=%0d,",
                      " got re=%h im=%h depth=%0d st=%0d"},
                     want.top_re, want.top_im, want.depth, want.status,
                     got.top_re, got.top_im, got.depth, got.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    logic [2:0] act;
    int r;
    for (int i = 0; i < crsa_pkg::StackDepth; i++) begin
      stk_re[i] = '0;
      stk_im[i] = '0;
    end
    rows = '{
      '{crsa_pkg::ActAdd, 0, 0, 1, '{crsa_pkg::StFew, 5'd0, 32'sd0, 32'sd0}},
      '{ActBad6, 0, 0, 1, '{crsa_pkg::StBadAct, 5'd0, 32'sd0, 32'sd0}},
      '{ActBad7, -1, -1, 1, '{crsa_pkg::StBadAct, 5'd0, 32'sd0, 32'sd0}},
      '{crsa_pkg::ActPush, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, '0},
      '{crsa_pkg::ActMul, 0, 0, 1,
        '{crsa_pkg::StFew, 5'd1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF}},
      '{crsa_pkg::ActPush, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, '0},
      '{crsa_pkg::ActAdd, 0, 0, 0, '0},
      '{crsa_pkg::ActPush, 32'sh8000_0000, 32'sh8000_0000, 0, '0},
      '{crsa_pkg::ActSub, 0, 0, 0, '0},
      '{crsa_pkg::ActPush, 0, 0, 0, '0},
      '{crsa_pkg::ActPush, 32'sh0001_0000, 0, 0, '0},
      '{crsa_pkg::ActDiv, 0, 0, 1,
        '{crsa_pkg::StDivZero, 5'd3, 32'sd0, 32'sh0001_0000}},
      '{crsa_pkg::ActMul, 0, 0, 0, '0},
      '{crsa_pkg::ActDiv, 0, 0, 0, '0},
      '{crsa_pkg::ActPush, 32'sh0003_0000, 32'sh0004_0000, 0, '0},
      '{crsa_pkg::ActDiv, 0, 0, 0, '0},
      '{crsa_pkg::ActClear, 0, 0, 1, '{crsa_pkg::StOk, 5'd0, 32'sd0, 32'sd0}},
      '{crsa_pkg::ActClear, 0, 0, 1, '{crsa_pkg::StOk, 5'd0, 32'sd0, 32'sd0}}
    };
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    foreach (rows[i]) send_word(rows[i].act, rows[i].re, rows[i].im, rows[i].typed,
                                rows[i].res);
    // fill the stack and push once more
    for (int i = 0; i <= crsa_pkg::StackDepth; i++)
      send_word(crsa_pkg::ActPush, rand_part(), rand_part(), 0, '0);
    for (int n = 0; n < NumRandom; n++) begin
      quiet = (n >= 300 && n < 400);
      if (n == 150) begin
        fork
          begin
            hold_req = 1'b1;
            repeat (400) @(posedge clk);
            hold_req = 1'b0;
          end
        join_none
      end
      if (n == 500) begin
        s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge clk);
      end
      r = $urandom_range(99);
      if (r < 42) act = crsa_pkg::ActPush;
      else if (r < 90) act = 3'($urandom_range(crsa_pkg::ActAdd, crsa_pkg::ActDiv));
      else if (r < 94) act = crsa_pkg::ActClear;
      else if (r < 97) act = ActBad6;
      else act = ActBad7;
      send_word(act, rand_part(), rand_part(), 0, '0);
    end
    s_axis_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

>>> files.f
rtl/crsa_pkg.sv
rtl/crsa_ram.sv
rtl/complex_rpn_stack_alu.sv
tb/tb_complex_rpn_stack_alu.sv
